>>> design/dsma_pkg.sv
// Shared types and constants for the decimal sign-magnitude ALU.
// No dependencies; imported by every module of the block.
`default_nettype none

package dsma_pkg;

  localparam logic [3:0] DigitMax = 4'd9;

  // Request action codes
  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_START  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // Operation codes carried by a start request
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_e;

  // Modes of the shared digit unit
  typedef enum logic [1:0] {
    UNIT_ADD = 2'd0,
    UNIT_SUB = 2'd1,
    UNIT_MAC = 2'd2
  } unit_mode_e;

  // Motion of the rotating result line
  typedef enum logic [1:0] {
    MV_HOLD = 2'd0,
    MV_FWD  = 2'd1,
    MV_REV  = 2'd2
  } move_e;

  typedef struct packed {
    move_e      mv;
    logic       wr;
    logic [3:0] data;
  } work_cmd_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEEK,
    ST_CMP,
    ST_ADDSUB,
    ST_CARRY,
    ST_MUL,
    ST_MULCARRY,
    ST_MULSKIP,
    ST_DSHIFT,
    ST_DCMP,
    ST_DSUB,
    ST_DQWR,
    ST_EMIT,
    ST_DZERO
  } state_e;

endpackage

`default_nettype wire

>>> design/dsma_unit.sv
// Shared decimal digit unit: add, subtract with borrow, or multiply-accumulate.
// Depends on dsma_pkg.
`default_nettype none

module dsma_unit import dsma_pkg::*; (
  input  unit_mode_e mode_i,
  input  logic [3:0] x_i,
  input  logic [3:0] y_i,
  input  logic [3:0] m_i,
  input  logic [3:0] cin_i,
  output logic [3:0] digit_o,
  output logic [3:0] cout_o
);

  logic signed [9:0] sum;
  logic        [7:0] prod;
  logic        [7:0] sum_u;
  logic       [15:0] recip;
  logic        [3:0] quo;

  // Form the raw digit sum
  always_comb begin
    prod = 8'(x_i * 8'd0) + 8'(m_i) * 8'(y_i);
    case (mode_i)
      UNIT_ADD: sum = 10'(x_i) + 10'(y_i) + 10'(cin_i);
      UNIT_SUB: sum = 10'(x_i) - 10'(y_i) - 10'(cin_i);
      UNIT_MAC: sum = 10'(x_i) + 10'(prod) + 10'(cin_i);
      default:  sum = '0;
    endcase
  end

  // Split into digit and carry; divide by ten through a reciprocal
  always_comb begin
    sum_u = sum[7:0];
    recip = 16'(sum_u) * 16'd205;
    quo   = recip[14:11];
    if (sum[9]) begin
      digit_o = 4'(sum + 10'sd10);
      cout_o  = 4'd1;
    end else begin
      digit_o = 4'(sum_u - 8'(quo) * 8'd10);
      cout_o  = quo;
    end
  end

endmodule

`default_nettype wire

>>> design/dsma_work.sv
// Rotating result line: one tap, moves forward or back, writes at the tap.
// Depends on dsma_pkg.
`default_nettype none

module dsma_work import dsma_pkg::*; #(
  parameter int unsigned Len = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  work_cmd_t               cmd_i,
  output logic [3:0]              tap_o,
  output logic [$clog2(Len)-1:0]  pos_o
);

  localparam int unsigned PW = $clog2(Len);
  localparam logic [PW-1:0] LastPos = PW'(Len - 1);

  logic [3:0]    w_q [Len];
  logic [3:0]    w_d [Len];
  logic [PW-1:0] pos_q, pos_d;
  logic [3:0]    cur;

  // Rotate the line, placing the written value where the tap was
  always_comb begin
    cur = cmd_i.wr ? cmd_i.data : w_q[0];
    w_d = w_q;
    pos_d = pos_q;
    case (cmd_i.mv)
      MV_FWD: begin
        for (int k = 0; k < Len - 1; k++) w_d[k] = w_q[k+1];
        w_d[Len-1] = cur;
        pos_d = (pos_q == LastPos) ? '0 : pos_q + 1'b1;
      end
      MV_REV: begin
        for (int k = 2; k < Len; k++) w_d[k] = w_q[k-1];
        w_d[0] = w_q[Len-1];
        w_d[1] = cur;
        pos_d = (pos_q == '0) ? LastPos : pos_q - 1'b1;
      end
      default: w_d[0] = cur;
    endcase
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign tap_o = w_q[0];
  assign pos_o = pos_q;

endmodule

`default_nettype wire

>>> design/decimal_signed_magnitude_alu.sv
// Top level of the decimal sign-magnitude ALU: operand store and sequencer.
// Depends on dsma_pkg, dsma_unit and dsma_work.
`default_nettype none

// Digits of A and B load one per cycle, most significant first, while busy_o
// is low. A start request runs the operation through one shared digit unit
// and a rotating 2*DIGITS result line: a clear sweep of the line, then a
// seek. Add or subtract then compares magnitudes when the signs differ and
// works one digit a cycle, multiply accumulates the partial products, and
// divide runs a digit-serial compare and subtract over the remainder. Add,
// subtract and multiply then move the tap to the top digit. The result line
// is walked from the top: leading zeros are skipped and each remaining digit
// leaves on a one-cycle result_valid_o strobe, one digit per cycle. A divide
// by a zero B sends a single zero digit with divide_by_zero_o instead. The
// receiver cannot stall: every strobe must be taken.
module decimal_signed_magnitude_alu import dsma_pkg::*; #(
  parameter int unsigned DIGITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] action_i,
  input  logic [3:0] digit_i,
  input  logic       is_negative_i,
  input  logic [1:0] opcode_i,
  output logic       result_valid_o,
  output logic [3:0] result_digit_o,
  output logic       result_negative_o,
  output logic       last_o,
  output logic       divide_by_zero_o
);

  localparam int unsigned L  = 2 * DIGITS;
  localparam int unsigned PW = $clog2(L);
  localparam int unsigned IW = $clog2(DIGITS);
  localparam int unsigned RL = DIGITS + 1;
  localparam int unsigned KW = $clog2(RL);
  localparam int unsigned CW = $clog2(DIGITS + 1);
  localparam logic [PW-1:0] PosTop  = PW'(L - 1);
  localparam logic [PW-1:0] PosDm1  = PW'(DIGITS - 1);
  localparam logic [IW-1:0] IMax    = IW'(DIGITS - 1);
  localparam logic [KW-1:0] KTop    = KW'(DIGITS);
  localparam logic [CW-1:0] CntFull = CW'(DIGITS);

  // Registers
  logic [3:0]    a_q [DIGITS];
  logic [3:0]    a_d [DIGITS];
  logic [3:0]    b_q [DIGITS];
  logic [3:0]    b_d [DIGITS];
  logic [3:0]    rem_q [DIGITS];
  logic [3:0]    rem_d [DIGITS];
  logic [3:0]    rem_hi_q, rem_hi_d;
  logic [CW-1:0] a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic          a_sign_q, a_sign_d, b_sign_q, b_sign_d, b_nz_q, b_nz_d;
  state_e        state_q, state_d, seek_next_q, seek_next_d;
  logic [PW-1:0] seek_tgt_q, seek_tgt_d, cnt_q, cnt_d;
  opcode_e       op_q, op_d;
  logic          sign_q, sign_d, esb_q, esb_d, swap_q, swap_d, sub_q, sub_d;
  logic          started_q, started_d;
  logic [3:0]    carry_q, carry_d, qd_q, qd_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic [KW-1:0] k_q, k_d;
  logic          vld_q, vld_d, neg_q, neg_d, last_q, last_d, dz_q, dz_d;
  logic [3:0]    dig_q, dig_d;

  // Shared unit and result line
  unit_mode_e    u_mode;
  logic [3:0]    u_x, u_y, u_m, u_cin, u_digit, u_cout;
  work_cmd_t     wcmd;
  logic [3:0]    tap;
  logic [PW-1:0] pos;

  dsma_unit u_unit (
    .mode_i (u_mode),
    .x_i    (u_x),
    .y_i    (u_y),
    .m_i    (u_m),
    .cin_i  (u_cin),
    .digit_o(u_digit),
    .cout_o (u_cout)
  );

  dsma_work #(.Len(L)) u_work (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (wcmd),
    .tap_o (tap),
    .pos_o (pos)
  );

  // Shared conditions
  logic       req_acc, rem_gt, rem_lt, div_ge, emit_now;
  logic [3:0] a_i_dig, a_j_dig, b_j_dig, rem_k, div_k, ld_dig;
  action_e    act;

  assign busy_o   = (state_q != ST_IDLE);
  assign req_acc  = start_i && !busy_o;
  assign act      = action_e'(action_i);
  assign ld_dig   = (digit_i > DigitMax) ? DigitMax : digit_i;
  assign a_i_dig  = a_q[i_q];
  assign a_j_dig  = a_q[j_q];
  assign b_j_dig  = b_q[j_q];
  assign rem_k    = (k_q == KTop) ? rem_hi_q : rem_q[k_q[IW-1:0]];
  assign div_k    = (k_q == KTop) ? 4'd0 : b_q[k_q[IW-1:0]];
  assign rem_gt   = rem_k > div_k;
  assign rem_lt   = rem_k < div_k;
  assign div_ge   = rem_gt || (!rem_lt && k_q == '0);
  assign emit_now = started_q || (tap != 4'd0) || (pos == '0);

  // Feed the digit unit
  always_comb begin
    u_mode = UNIT_ADD;
    u_x    = 4'd0;
    u_y    = 4'd0;
    u_m    = 4'd0;
    u_cin  = carry_q;
    case (state_q)
      ST_ADDSUB: begin
        u_mode = sub_q ? UNIT_SUB : UNIT_ADD;
        u_x    = swap_q ? b_j_dig : a_j_dig;
        u_y    = swap_q ? a_j_dig : b_j_dig;
      end
      ST_MUL: begin
        u_mode = UNIT_MAC;
        u_x    = tap;
        u_y    = b_j_dig;
        u_m    = a_i_dig;
      end
      ST_DSUB: begin
        u_mode = UNIT_SUB;
        u_x    = rem_k;
        u_y    = div_k;
      end
      default: u_mode = UNIT_ADD;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc && act == ACT_START) begin
          state_d = (opcode_e'(opcode_i) == OP_DIV && !b_nz_q) ? ST_DZERO : ST_CLEAR;
        end
      end
      ST_CLEAR:    if (cnt_q == PosTop) state_d = ST_SEEK;
      ST_SEEK:     if (pos == seek_tgt_q) state_d = seek_next_q;
      ST_CMP: begin
        if (a_j_dig != b_j_dig) state_d = ST_ADDSUB;
        else if (j_q == '0) state_d = ST_SEEK;
      end
      ST_ADDSUB:   if (j_q == IMax) state_d = ST_CARRY;
      ST_CARRY:    state_d = ST_SEEK;
      ST_MUL:      if (j_q == IMax) state_d = ST_MULCARRY;
      ST_MULCARRY: state_d = (i_q == IMax) ? ST_SEEK : ST_MULSKIP;
      ST_MULSKIP:  if (cnt_q == PosDm1) state_d = ST_MUL;
      ST_DSHIFT:   state_d = ST_DCMP;
      ST_DCMP: begin
        if (div_ge) state_d = (qd_q < DigitMax) ? ST_DSUB : ST_DQWR;
        else if (rem_lt) state_d = ST_DQWR;
      end
      ST_DSUB:     if (k_q == KTop) state_d = ST_DCMP;
      ST_DQWR:     state_d = (i_q == '0) ? ST_EMIT : ST_DSHIFT;
      ST_EMIT:     if (emit_now && pos == '0) state_d = ST_IDLE;
      ST_DZERO:    state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and result outputs
  always_comb begin
    a_d = a_q;  b_d = b_q;  rem_d = rem_q;  rem_hi_d = rem_hi_q;
    a_cnt_d = a_cnt_q;  b_cnt_d = b_cnt_q;
    a_sign_d = a_sign_q;  b_sign_d = b_sign_q;  b_nz_d = b_nz_q;
    seek_next_d = seek_next_q;  seek_tgt_d = seek_tgt_q;  cnt_d = cnt_q;
    op_d = op_q;  sign_d = sign_q;  esb_d = esb_q;  swap_d = swap_q;  sub_d = sub_q;
    started_d = started_q;  carry_d = carry_q;  qd_d = qd_q;
    i_d = i_q;  j_d = j_q;  k_d = k_q;
    vld_d = 1'b0;  neg_d = 1'b0;  last_d = 1'b0;  dz_d = 1'b0;  dig_d = 4'd0;
    wcmd = '{mv: MV_HOLD, wr: 1'b0, data: 4'd0};

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          case (act)
            ACT_LOAD_A: begin
              a_sign_d = is_negative_i;
              if (a_cnt_q < CntFull) begin
                for (int k = 1; k < DIGITS; k++) a_d[k] = a_q[k-1];
                a_d[0] = ld_dig;
                a_cnt_d = a_cnt_q + 1'b1;
              end
            end
            ACT_LOAD_B: begin
              b_sign_d = is_negative_i;
              if (b_cnt_q < CntFull) begin
                for (int k = 1; k < DIGITS; k++) b_d[k] = b_q[k-1];
                b_d[0] = ld_dig;
                b_cnt_d = b_cnt_q + 1'b1;
                b_nz_d = b_nz_q || (ld_dig != 4'd0);
              end
            end
            ACT_START: begin
              op_d  = opcode_e'(opcode_i);
              esb_d = b_sign_q ^ (opcode_e'(opcode_i) == OP_SUB);
              cnt_d = '0;
              started_d = 1'b0;
            end
            default: cnt_d = cnt_q;
          endcase
        end
      end

      // Zero the result line, then set up the chosen operation
      ST_CLEAR: begin
        wcmd = '{mv: MV_FWD, wr: 1'b1, data: 4'd0};
        cnt_d = cnt_q + 1'b1;
        i_d = '0;  j_d = '0;  carry_d = 4'd0;
        seek_tgt_d = '0;
        sign_d = a_sign_q ^ b_sign_q;
        case (op_q)
          OP_ADD, OP_SUB: begin
            swap_d = 1'b0;
            sub_d  = 1'b0;
            if (a_sign_q == esb_q) begin
              sign_d = a_sign_q;
              seek_next_d = ST_ADDSUB;
            end else begin
              j_d = IMax;
              seek_next_d = ST_CMP;
            end
          end
          OP_MUL: seek_next_d = ST_MUL;
          default: begin
            i_d = IMax;
            seek_tgt_d = PosDm1;
            seek_next_d = ST_DSHIFT;
            for (int k = 0; k < DIGITS; k++) rem_d[k] = 4'd0;
            rem_hi_d = 4'd0;
          end
        endcase
      end

      ST_SEEK: begin
        if (pos != seek_tgt_q) wcmd.mv = MV_FWD;
      end

      // Find the larger magnitude, most significant digit first
      ST_CMP: begin
        if (a_j_dig != b_j_dig) begin
          swap_d = a_j_dig < b_j_dig;
          sign_d = (a_j_dig < b_j_dig) ? esb_q : a_sign_q;
          sub_d = 1'b1;
          j_d = '0;
        end else if (j_q == '0) begin
          sign_d = 1'b0;
          seek_tgt_d = PosTop;
          seek_next_d = ST_EMIT;
        end else begin
          j_d = j_q - 1'b1;
        end
      end

      ST_ADDSUB: begin
        wcmd = '{mv: MV_FWD, wr: 1'b1, data: u_digit};
        carry_d = u_cout;
        j_d = (j_q == IMax) ? '0 : j_q + 1'b1;
      end

      ST_CARRY: begin
        wcmd = '{mv: MV_FWD, wr: 1'b1, data: sub_q ? 4'd0 : carry_q};
        seek_tgt_d = PosTop;
        seek_next_d = ST_EMIT;
      end

      // Accumulate one partial product digit
      ST_MUL: begin
        wcmd = '{mv: MV_FWD, wr: 1'b1, data: u_digit};
        carry_d = u_cout;
        j_d = (j_q == IMax) ? '0 : j_q + 1'b1;
      end

      ST_MULCARRY: begin
        wcmd = '{mv: MV_FWD, wr: 1'b1, data: carry_q};
        carry_d = 4'd0;
        cnt_d = '0;
        if (i_q == IMax) begin
          seek_tgt_d = PosTop;
          seek_next_d = ST_EMIT;
        end else begin
          i_d = i_q + 1'b1;
        end
      end

      // Advance the tap back to the start of the next row
      ST_MULSKIP: begin
        wcmd.mv = MV_FWD;
        cnt_d = cnt_q + 1'b1;
      end

      // Shift the next dividend digit into the remainder
      ST_DSHIFT: begin
        rem_hi_d = rem_q[DIGITS-1];
        for (int k = 1; k < DIGITS; k++) rem_d[k] = rem_q[k-1];
        rem_d[0] = a_i_dig;
        qd_d = 4'd0;
        k_d = KTop;
      end

      ST_DCMP: begin
        if (div_ge) begin
          k_d = '0;
          carry_d = 4'd0;
        end else if (!rem_lt) begin
          k_d = k_q - 1'b1;
        end
      end

      // Subtract the divisor from the remainder, one digit a cycle
      ST_DSUB: begin
        if (k_q == KTop) begin
          rem_hi_d = u_digit;
        end else begin
          rem_d[k_q[IW-1:0]] = u_digit;
        end
        carry_d = u_cout;
        if (k_q == KTop) begin
          qd_d = qd_q + 1'b1;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      ST_DQWR: begin
        wcmd = '{mv: MV_REV, wr: 1'b1, data: qd_q};
        if (i_q != '0) i_d = i_q - 1'b1;
      end

      // Skip leading zeros, then send digits most significant first
      ST_EMIT: begin
        wcmd.mv = MV_REV;
        if (emit_now) begin
          vld_d = 1'b1;
          dig_d = tap;
          neg_d = sign_q && (started_q || tap != 4'd0);
          last_d = (pos == '0);
          started_d = 1'b1;
        end
      end

      ST_DZERO: begin
        vld_d = 1'b1;
        last_d = 1'b1;
        dz_d = 1'b1;
      end

      default: wcmd.mv = MV_HOLD;
    endcase

    // Drop both operands once the run is finished
    if ((state_q == ST_EMIT && emit_now && pos == '0) || state_q == ST_DZERO) begin
      for (int k = 0; k < DIGITS; k++) begin
        a_d[k] = 4'd0;
        b_d[k] = 4'd0;
      end
      a_cnt_d = '0;  b_cnt_d = '0;
      a_sign_d = 1'b0;  b_sign_d = 1'b0;  b_nz_d = 1'b0;
    end
  end

  // Control and operand registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      for (int k = 0; k < DIGITS; k++) begin
        a_q[k] <= 4'd0;
        b_q[k] <= 4'd0;
      end
      a_cnt_q  <= '0;
      b_cnt_q  <= '0;
      a_sign_q <= 1'b0;
      b_sign_q <= 1'b0;
      b_nz_q   <= 1'b0;
      vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      a_q      <= a_d;
      b_q      <= b_d;
      a_cnt_q  <= a_cnt_d;
      b_cnt_q  <= b_cnt_d;
      a_sign_q <= a_sign_d;
      b_sign_q <= b_sign_d;
      b_nz_q   <= b_nz_d;
      vld_q    <= vld_d;
    end
  end

  // Working payload registers
  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    rem_hi_q    <= rem_hi_d;
    seek_next_q <= seek_next_d;
    seek_tgt_q  <= seek_tgt_d;
    cnt_q       <= cnt_d;
    op_q        <= op_d;
    sign_q      <= sign_d;
    esb_q       <= esb_d;
    swap_q      <= swap_d;
    sub_q       <= sub_d;
    started_q   <= started_d;
    carry_q     <= carry_d;
    qd_q        <= qd_d;
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    dig_q       <= dig_d;
    neg_q       <= neg_d;
    last_q      <= last_d;
    dz_q        <= dz_d;
  end

  assign result_valid_o    = vld_q;
  assign result_digit_o    = dig_q;
  assign result_negative_o = neg_q;
  assign last_o            = last_q;
  assign divide_by_zero_o  = dz_q;

`ifndef NO_ASSERTIONS
  a_strobe_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result strobe without a running request");

  a_dz_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && divide_by_zero_o) |-> (last_o && result_digit_o == 4'd0))
    else $error("divide by zero result is not a single zero digit");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy_o)
    else $error("result run stopped before its last digit");

  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("block went busy without a request");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_decimal_signed_magnitude_alu.sv
// Self-checking bench for the decimal sign-magnitude ALU: loads, operations, result digits.
// Depends on dsma_pkg and decimal_signed_magnitude_alu.
`default_nettype none

module tb_decimal_signed_magnitude_alu import dsma_pkg::*; ();

  localparam int unsigned NDIG = 32;
  localparam int unsigned WLEN = 2 * NDIG;
  localparam int unsigned RLEN = NDIG + 1;
  localparam int unsigned STALL_LIMIT = 400000;

  typedef struct packed {
    action_e    act;
    logic [3:0] dig;
    logic       neg;
    opcode_e    op;
  } request_t;

  typedef struct packed {
    logic [3:0] dig;
    logic       neg;
    logic       lst;
    logic       dz;
  } digit_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [1:0] action_i = '0;
  logic [3:0] digit_i = '0;
  logic is_negative_i = 1'b0;
  logic [1:0] opcode_i = '0;
  logic busy_o, result_valid_o, result_negative_o, last_o, divide_by_zero_o;
  logic [3:0] result_digit_o;

  request_t   pending_q[$];
  digit_out_t expected_digits_q[$];
  int         fail_count = 0;
  int         idle_cycles = 0;
  int         gap_left = 0;
  bit         stim_done = 1'b0;

  // Operand copies held least significant first
  logic [3:0] a_mag[NDIG];
  logic [3:0] b_mag[NDIG];
  int         a_len, b_len;
  logic       a_neg, b_neg;
  logic [3:0] prod[WLEN];

  decimal_signed_magnitude_alu #(.DIGITS(NDIG)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .digit_i, .is_negative_i, .opcode_i,
    .result_valid_o, .result_digit_o, .result_negative_o, .last_o, .divide_by_zero_o
  );

  always #10 clk_i = ~clk_i;

  function automatic int cmp_mag(input logic [3:0] x[RLEN], input logic [3:0] y[RLEN]);
    for (int k = RLEN - 1; k >= 0; k--) begin
      if (x[k] > y[k]) return 1;
      if (x[k] < y[k]) return -1;
    end
    return 0;
  endfunction

  task automatic clear_operands();
    for (int k = 0; k < NDIG; k++) begin
      a_mag[k] = '0;
      b_mag[k] = '0;
    end
    a_len = 0; b_len = 0; a_neg = 1'b0; b_neg = 1'b0;
  endtask

  // Push the trimmed product digits, most significant first
  task automatic push_digits(input logic sgn);
    int top;
    digit_out_t d;
    top = WLEN - 1;
    while (top > 0 && prod[top] == 0) top--;
    if (top == 0 && prod[0] == 0) sgn = 1'b0;
    for (int k = top; k >= 0; k--) begin
      d.dig = prod[k]; d.neg = sgn; d.lst = (k == 0); d.dz = 1'b0;
      expected_digits_q.push_back(d);
    end
  endtask

  // Add or subtract magnitudes with signs sa, sb; fill prod and return the sign
  function automatic logic add_signed(input logic sa, input logic sb);
    int t, c;
    logic [3:0] x[RLEN], y[RLEN];
    for (int k = 0; k < WLEN; k++) prod[k] = '0;
    for (int k = 0; k < RLEN; k++) begin
      x[k] = (k < NDIG) ? a_mag[k] : 4'd0;
      y[k] = (k < NDIG) ? b_mag[k] : 4'd0;
    end
    c = 0;
    if (sa == sb) begin
      for (int k = 0; k < NDIG; k++) begin
        t = x[k] + y[k] + c;
        prod[k] = 4'(t % 10); c = t / 10;
      end
      prod[NDIG] = 4'(c);
      return sa;
    end
    case (cmp_mag(x, y))
      0: return 1'b0;
      1: begin
        for (int k = 0; k < NDIG; k++) begin
          t = x[k] - y[k] - c; c = (t < 0); prod[k] = 4'((t + 10) % 10);
        end
        return sa;
      end
      default: begin
        for (int k = 0; k < NDIG; k++) begin
          t = y[k] - x[k] - c; c = (t < 0); prod[k] = 4'((t + 10) % 10);
        end
        return sb;
      end
    endcase
  endfunction

  // Work out the result digits of one accepted request
  task automatic predict_request(input request_t r);
    int t, c, q;
    logic bz;
    logic [3:0] rem[RLEN], dv[RLEN];
    case (r.act)
      ACT_LOAD_A, ACT_LOAD_B: begin
        if (r.act == ACT_LOAD_A) begin
          a_neg = r.neg;
          if (a_len < NDIG) begin
            for (int k = NDIG - 1; k > 0; k--) a_mag[k] = a_mag[k - 1];
            a_mag[0] = (r.dig > DigitMax) ? DigitMax : r.dig;
            a_len++;
          end
        end else begin
          b_neg = r.neg;
          if (b_len < NDIG) begin
            for (int k = NDIG - 1; k > 0; k--) b_mag[k] = b_mag[k - 1];
            b_mag[0] = (r.dig > DigitMax) ? DigitMax : r.dig;
            b_len++;
          end
        end
      end
      ACT_START: begin
        case (r.op)
          OP_ADD: push_digits(add_signed(a_neg, b_neg));
          OP_SUB: push_digits(add_signed(a_neg, ~b_neg));
          OP_MUL: begin
            for (int k = 0; k < WLEN; k++) prod[k] = '0;
            for (int i = 0; i < NDIG; i++) begin
              c = 0;
              for (int j = 0; j < NDIG; j++) begin
                t = prod[i + j] + a_mag[i] * b_mag[j] + c;
                prod[i + j] = 4'(t % 10); c = t / 10;
              end
              prod[i + NDIG] = 4'(c);
            end
            push_digits(a_neg ^ b_neg);
          end
          default: begin
            bz = 1'b1;
            for (int k = 0; k < NDIG; k++) if (b_mag[k] != 0) bz = 1'b0;
            if (bz) begin
              expected_digits_q.push_back('{dig: 4'd0, neg: 1'b0, lst: 1'b1, dz: 1'b1});
            end else begin
              for (int k = 0; k < WLEN; k++) prod[k] = '0;
              for (int k = 0; k < RLEN; k++) begin
                rem[k] = '0;
                dv[k] = (k < NDIG) ? b_mag[k] : 4'd0;
              end
              for (int i = NDIG - 1; i >= 0; i--) begin
                for (int k = RLEN - 1; k > 0; k--) rem[k] = rem[k - 1];
                rem[0] = a_mag[i];
                q = 0;
                while (cmp_mag(rem, dv) >= 0 && q < 9) begin
                  c = 0;
                  for (int k = 0; k < RLEN; k++) begin
                    t = rem[k] - dv[k] - c; c = (t < 0); rem[k] = 4'((t + 10) % 10);
                  end
                  q++;
                end
                prod[i] = 4'(q);
              end
              push_digits(a_neg ^ b_neg);
            end
          end
        endcase
        clear_operands();
      end
      default: ;
    endcase
  endtask

  function automatic request_t make_req(input action_e a, input logic [3:0] d, input logic n,
                                        input opcode_e o);
    request_t r;
    r.act = a; r.dig = d; r.neg = n; r.op = o;
    return r;
  endfunction

  // Queue one operand of len random digits, a few of them above nine
  task automatic queue_operand(input action_e a, input int len, input logic n);
    for (int k = 0; k < len; k++)
      pending_q.push_back(make_req(a, ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                      : 4'($urandom_range(0, 9)), n, OP_ADD));
  endtask

  function automatic int pick_len();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return 0;
    if (p == 1) return NDIG + $urandom_range(0, 3);
    if (p < 5) return $urandom_range(5, NDIG);
    return $urandom_range(1, 4);
  endfunction

  // Fill the request queue: directed cases first, then random operations
  initial begin
    clear_operands();
    // Largest magnitudes, overflow of operand A, sign update after overflow
    for (int k = 0; k < NDIG + 2; k++)
      pending_q.push_back(make_req(ACT_LOAD_A, 4'd15, k[0], OP_ADD));
    pending_q.push_back(make_req(ACT_LOAD_B, 4'd9, 1'b1, OP_ADD));
    pending_q.push_back(make_req(ACT_START, 4'd0, 1'b0, OP_MUL));
    // Empty operands, negative zero, action three ignored
    pending_q.push_back(make_req(ACT_LOAD_A, 4'd0, 1'b1, OP_ADD));
    pending_q.push_back(make_req(ACT_NONE, 4'd5, 1'b1, OP_DIV));
    pending_q.push_back(make_req(ACT_START, 4'd0, 1'b0, OP_ADD));
    pending_q.push_back(make_req(ACT_START, 4'd0, 1'b0, OP_DIV));
    // Equal magnitudes of opposite sign, then subtraction and division
    pending_q.push_back(make_req(ACT_LOAD_A, 4'd7, 1'b1, OP_ADD));
    pending_q.push_back(make_req(ACT_LOAD_B, 4'd7, 1'b0, OP_ADD));
    pending_q.push_back(make_req(ACT_START, 4'd0, 1'b0, OP_ADD));
    pending_q.push_back(make_req(ACT_LOAD_A, 4'd3, 1'b0, OP_ADD));
    pending_q.push_back(make_req(ACT_LOAD_B, 4'd8, 1'b1, OP_ADD));
    pending_q.push_back(make_req(ACT_START, 4'd0, 1'b0, OP_SUB));
    pending_q.push_back(make_req(ACT_LOAD_A, 4'd9, 1'b1, OP_ADD));
    pending_q.push_back(make_req(ACT_LOAD_A, 4'd9, 1'b1, OP_ADD));
    pending_q.push_back(make_req(ACT_LOAD_B, 4'd2, 1'b0, OP_ADD));
    pending_q.push_back(make_req(ACT_START, 4'd0, 1'b1, OP_DIV));
    // Random well-formed sequences with some noise
    while (pending_q.size() < 300) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_q.push_back(make_req(action_e'(2'($urandom_range(0, 3))), 4'($urandom),
                                     1'($urandom), opcode_e'(2'($urandom))));
      end else begin
        queue_operand(ACT_LOAD_A, pick_len(), 1'($urandom));
        queue_operand(ACT_LOAD_B, pick_len(), 1'($urandom));
        pending_q.push_back(make_req(ACT_START, 4'($urandom), 1'($urandom),
                                     opcode_e'(2'($urandom))));
      end
    end
    pending_q.push_back(make_req(ACT_START, 4'd0, 1'b0, OP_SUB));
    stim_done = 1'b1;
  end

  // Hold reset low at the start, then release it
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Drive requests from the queue with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_request(request_t'{action_e'(action_i), digit_i, is_negative_i,
                                   opcode_e'(opcode_i)});
        void'(pending_q.pop_front());
        gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                 : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
      end
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        start_i <= 1'b1;
        action_i <= pending_q[0].act;
        digit_i <= pending_q[0].dig;
        is_negative_i <= pending_q[0].neg;
        opcode_i <= pending_q[0].op;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Check each result digit against the oldest expectation
  always @(posedge clk_i) begin
    digit_out_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_digits_q.size() == 0) begin
        $error("unexpected result digit %0d", result_digit_o);
        fail_count++;
      end else begin
        e = expected_digits_q.pop_front();
        if (result_digit_o !== e.dig) begin
          $error("result_digit: expected %0d, got %0d", e.dig, result_digit_o); fail_count++;
        end
        if (result_negative_o !== e.neg) begin
          $error("result_negative: expected %0b, got %0b", e.neg, result_negative_o);
          fail_count++;
        end
        if (last_o !== e.lst) begin
          $error("last: expected %0b, got %0b", e.lst, last_o); fail_count++;
        end
        if (divide_by_zero_o !== e.dz) begin
          $error("divide_by_zero: expected %0b, got %0b", e.dz, divide_by_zero_o);
          fail_count++;
        end
      end
    end
  end

  // Count cycles with no accepted request or result
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Wait for the end of stimulus and all results, or give up on a stall
  initial begin
    wait (rst_ni);
    while (!(stim_done && pending_q.size() == 0 && expected_digits_q.size() == 0 && !busy_o)
           && idle_cycles < STALL_LIMIT)
      @(posedge clk_i);
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
    end else begin
      repeat (200) @(posedge clk_i);
      if (fail_count == 0 && expected_digits_q.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
